### rtl/intd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intd_pkg: shared types and constants of the distributor register bank
// Access function codes, decode kinds, memory regions and the state encoding.
// ----------------------------------------------------------------------------
package intd_pkg;

	// bus access functions
	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_BYTE  = 2'd2;
	localparam logic [1:0] FUNC_RSVD  = 2'd3;

	// hard architectural ceiling on interrupt lines
	localparam int MAX_LINES = 1020;

	// word offsets (offset[11:2]) of the single registers
	localparam logic [9:0] WOFF_CTRL = 10'h000;
	localparam logic [9:0] WOFF_TYPE = 10'h001;

	// 128-byte pages (offset[11:7]) of the bit windows
	localparam logic [4:0] PAGE_GROUP  = 5'h01;
	localparam logic [4:0] PAGE_SETEN  = 5'h02;
	localparam logic [4:0] PAGE_CLREN  = 5'h03;
	localparam logic [4:0] PAGE_CLRPND = 5'h05;

	// 1 KiB quarters (offset[11:10]) of the byte windows
	localparam logic [1:0] QTR_PRIO   = 2'b01;
	localparam logic [1:0] QTR_TARGET = 2'b10;

	// memory regions (top two address bits)
	localparam logic [1:0] RGN_GROUP  = 2'd0;
	localparam logic [1:0] RGN_ENABLE = 2'd1;
	localparam logic [1:0] RGN_PRIO   = 2'd2;
	localparam logic [1:0] RGN_TARGET = 2'd3;

	typedef enum logic [2:0] {
		K_NONE,
		K_ERR,
		K_CTRL,
		K_TYPE,
		K_GROUP,
		K_SETEN,
		K_CLREN,
		K_BYTEWIN
	} kind_t;

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_RMW   = 3'b100
	} state_t;

	// decoded access, held for the read-modify-write cycle
	typedef struct packed {
		kind_t       kind;
		logic [1:0]  func;
		logic [1:0]  lane;
		logic [31:0] mask;
		logic [31:0] wdata;
	} acc_t;

endpackage

### rtl/interrupt_distributor_regs_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_distributor_regs_top: distributor register bank
// Control, type, group, enable, priority and target registers behind a
// simple command port; per-line state lives in one synchronous RAM.
// ----------------------------------------------------------------------------
// A beat taken while idle is presented with done high for the cycle after it,
// once the state register holds S_RMW, and the receiver takes it there.
// Beats do not overlap: busy stays high through the RAM read-modify-write
// (read in the accept cycle, modify and write back in the next).
// Reset: arst_n clears control state, then a clearing pass zeroes every
// RAM word with busy high.
// The receiver cannot stall: done is a one-cycle strobe.
module interrupt_distributor_regs_top
	import intd_pkg::*;
#(
	parameter int NUM_LINES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [11:0] offset,
	input  logic [31:0] wdata,
	output logic        done,
	output logic [31:0] rdata,
	output logic        access_error
);

	// implemented lines and array sizes
	localparam int LINES_IMPL = (NUM_LINES < MAX_LINES) ? NUM_LINES : MAX_LINES;
	localparam int BIT_WORDS  = (NUM_LINES + 31) / 32;
	localparam int BYTE_WORDS = (NUM_LINES + 3) / 4;
	localparam int IW         = (BYTE_WORDS > 1) ? $clog2(BYTE_WORDS) : 1;
	localparam int AW         = IW + 2;
	localparam int DEPTH      = 1 << AW;

	localparam logic [9:0] LIMPL      = 10'(LINES_IMPL);
	localparam logic [4:0] BW_MASK    = 5'(BIT_WORDS - 1);
	localparam logic [31:0] TYPE_WORD = {27'd0, BW_MASK};

	state_t          state_q;
	logic [AW-1:0]   clr_q;
	logic [1:0]      genable_q;

	acc_t            acc_d;
	acc_t            acc_s1;
	logic [AW-1:0]   addr_d;
	logic [AW-1:0]   addr_s1;

	logic [31:0]     mem [DEPTH];
	logic [31:0]     rd_q;

	logic            accept;
	logic [9:0]      woff;
	logic [4:0]      page;
	logic [4:0]      wsel;
	logic [7:0]      psel;
	logic [31:0]     bmask;
	logic [31:0]     pmask;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [31:0]     mem_wdata;
	logic [31:0]     new_word;
	logic            upd;
	logic [31:0]     res_data;
	logic            res_err;
	logic [31:0]     lane_bits;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign woff = offset[11:2];
	assign page = offset[11:7];
	assign wsel = offset[6:2];
	assign psel = offset[9:2];

	// Implemented-line masks: a bit or byte is live while its line number
	// stays below the implemented count.
	always_comb begin
		for (int j = 0; j < 32; j++) begin
			bmask[j] = ({wsel, 5'(j)} < LIMPL);
		end
		for (int k = 0; k < 4; k++) begin
			pmask[8*k +: 8] = {8{({psel, 2'(k)} < LIMPL)}};
		end
	end

	// Address decode, done in the accept cycle so the RAM read can start.
	always_comb begin
		acc_d       = '0;
		acc_d.kind  = K_ERR;
		acc_d.func  = func;
		acc_d.lane  = offset[1:0];
		acc_d.wdata = wdata;
		addr_d      = '0;
		if (func == FUNC_RSVD) begin
			acc_d.kind = K_ERR;
		end else if (offset[11:10] == QTR_PRIO || offset[11:10] == QTR_TARGET) begin
			acc_d.kind = K_BYTEWIN;
			acc_d.mask = pmask;
			addr_d     = {(offset[11:10] == QTR_PRIO) ? RGN_PRIO : RGN_TARGET,
			              IW'(psel)};
		end else if (func == FUNC_BYTE) begin
			acc_d.kind = K_ERR;
		end else if (woff == WOFF_CTRL) begin
			acc_d.kind = K_CTRL;
		end else if (woff == WOFF_TYPE) begin
			acc_d.kind = K_TYPE;
		end else begin
			case (page)
				PAGE_GROUP: begin
					acc_d.kind = K_GROUP;
					acc_d.mask = bmask;
					// reads fold the word index onto the low index bits
					if (func == FUNC_READ)
						addr_d = {RGN_GROUP, IW'(wsel & BW_MASK)};
					else
						addr_d = {RGN_GROUP, IW'(wsel)};
				end
				PAGE_SETEN: begin
					acc_d.kind = K_SETEN;
					acc_d.mask = bmask;
					addr_d     = {RGN_ENABLE, IW'(wsel)};
				end
				PAGE_CLREN: begin
					acc_d.kind = K_CLREN;
					acc_d.mask = bmask;
					addr_d     = {RGN_ENABLE, IW'(wsel)};
				end
				PAGE_CLRPND: begin
					acc_d.kind = K_NONE;
				end
				default: begin
					acc_d.kind = K_ERR;
				end
			endcase
		end
	end

	// Modify step: old word from the RAM, new word and read data out.
	always_comb begin
		lane_bits = (32'h0000_00ff << {acc_s1.lane, 3'b000}) & acc_s1.mask;
		new_word  = rd_q;
		upd       = 1'b0;
		res_data  = '0;
		res_err   = 1'b0;
		case (acc_s1.kind)
			K_NONE: begin
				res_data = '0;
			end
			K_ERR: begin
				res_err = 1'b1;
			end
			K_CTRL: begin
				res_data = {30'd0, genable_q};
			end
			K_TYPE: begin
				res_data = TYPE_WORD;
			end
			K_GROUP: begin
				res_data = rd_q & acc_s1.mask;
				new_word = acc_s1.wdata & acc_s1.mask;
				upd      = 1'b1;
			end
			K_SETEN: begin
				res_data = rd_q & acc_s1.mask;
				new_word = rd_q | (acc_s1.wdata & acc_s1.mask);
				upd      = 1'b1;
			end
			K_CLREN: begin
				res_data = rd_q & acc_s1.mask;
				new_word = rd_q & ~(acc_s1.wdata & acc_s1.mask);
				upd      = 1'b1;
			end
			K_BYTEWIN: begin
				res_data = rd_q & acc_s1.mask;
				upd      = 1'b1;
				if (acc_s1.func == FUNC_BYTE)
					new_word = (rd_q & ~lane_bits) |
					           (({24'd0, acc_s1.wdata[7:0]} << {acc_s1.lane, 3'b000})
					            & lane_bits);
				else
					new_word = acc_s1.wdata & acc_s1.mask;
			end
			default: begin
				res_err = 1'b1;
			end
		endcase
		if (acc_s1.func != FUNC_READ)
			res_data = '0;
	end

	// RAM write port: clearing pass, else the write-back of a live word
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = new_word;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_RMW: begin
				mem_we = upd && (acc_s1.func != FUNC_READ) && (acc_s1.mask != '0);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[addr_d];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			genable_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept)
						state_q <= S_RMW;
				end
				S_RMW: begin
					if (acc_s1.kind == K_CTRL && acc_s1.func == FUNC_WRITE)
						genable_q <= acc_s1.wdata[1:0];
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// decoded beat, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			acc_s1  <= acc_d;
			addr_s1 <= addr_d;
		end
	end

	assign done         = (state_q == S_RMW);
	assign rdata        = res_data;
	assign access_error = res_err;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept))
		else $error("result without an accepted beat");

	a_err_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && access_error) |-> (rdata == '0))
		else $error("error beat carries data");

	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && acc_s1.func != FUNC_READ) |-> (rdata == '0))
		else $error("write beat carries data");

	a_no_clear_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |=> (state_q != S_CLEAR))
		else $error("clearing pass re-entered");

endmodule

### dv/interrupt_distributor_regs_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_distributor_regs_top_tb: self-checking bench for the register bank
// Directed accesses to every window and its edges, then random word reads,
// word writes, byte writes and reserved functions with random gaps. Each beat
// is predicted by a shadow bank copy; every done strobe is compared in order.
// ----------------------------------------------------------------------------
module interrupt_distributor_regs_top_tb;
	import intd_pkg::*;

	localparam int LINES     = 256;
	localparam int RND_BEATS = 1200;

	// one predicted reply of the bank
	typedef struct {
		logic [31:0] rdata;
		logic        err;
	} reply_t;

	// Shadow register bank: mirrors the distributor state and queues the
	// reply each accepted beat should produce.
	class regbank_model #(int NL = 256);
		localparam int IMPL       = (NL < MAX_LINES) ? NL : MAX_LINES;
		localparam int BIT_WORDS  = (NL + 31) / 32;
		localparam int BYTE_WORDS = (NL + 3) / 4;

		logic [1:0]  group_en;
		logic [31:0] group_word  [BIT_WORDS];
		logic [31:0] enable_word [BIT_WORDS];
		logic [31:0] prio_word   [BYTE_WORDS];
		logic [31:0] target_word [BYTE_WORDS];
		reply_t      due_replies [$];
		int          errors;

		function new();
			group_en = '0;
			foreach (group_word[i]) group_word[i] = '0;
			foreach (enable_word[i]) enable_word[i] = '0;
			foreach (prio_word[i]) prio_word[i] = '0;
			foreach (target_word[i]) target_word[i] = '0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		// implemented lines among bit word w
		function logic [31:0] line_bits(int unsigned w);
			int unsigned n;
			if (w >= BIT_WORDS || w * 32 >= IMPL) return '0;
			n = IMPL - w * 32;
			if (n >= 32) return '1;
			return (32'd1 << n) - 32'd1;
		endfunction

		// implemented byte lanes among byte word p
		function logic [31:0] line_bytes(int unsigned p);
			int unsigned n;
			if (p >= BYTE_WORDS || p * 4 >= IMPL) return '0;
			n = IMPL - p * 4;
			if (n >= 4) return '1;
			return (32'd1 << (8 * n)) - 32'd1;
		endfunction

		// priority or target window, rel is the offset within the window
		function logic [31:0] byte_window(bit tgt, logic [1:0] f, logic [9:0] rel,
				logic [31:0] d);
			int unsigned p;
			int unsigned sh;
			logic [31:0] m;
			logic [31:0] bm;
			logic [31:0] cur;
			p = 32'(rel[9:2]);
			sh = 32'(rel[1:0]) * 8;
			m = line_bytes(p);
			if (m == '0) return '0;
			cur = tgt ? target_word[p] : prio_word[p];
			if (f == FUNC_READ) return cur & m;
			if (f == FUNC_WRITE) begin
				cur = d & m;
			end else begin
				bm = (32'hFF << sh) & m;
				cur = (cur & ~bm) | (((d & 32'hFF) << sh) & bm);
			end
			if (tgt) target_word[p] = cur;
			else prio_word[p] = cur;
			return '0;
		endfunction

		// work out the reply of one access and update the shadow state
		function reply_t predict_access(logic [1:0] f, logic [11:0] off,
				logic [31:0] d);
			reply_t r;
			logic [4:0] page;
			logic [4:0] w;
			logic [31:0] m;
			r.rdata = '0;
			r.err = 1'b0;
			page = off[11:7];
			w = off[6:2];
			m = line_bits(32'(w));
			if (f == FUNC_RSVD) begin
				r.err = 1'b1;
			end else if (off[11:10] == QTR_PRIO) begin
				r.rdata = byte_window(1'b0, f, off[9:0], d);
			end else if (off[11:10] == QTR_TARGET) begin
				r.rdata = byte_window(1'b1, f, off[9:0], d);
			end else if (f == FUNC_BYTE) begin
				r.err = 1'b1;
			end else if (off[11:2] == WOFF_CTRL) begin
				if (f == FUNC_READ) r.rdata = {30'd0, group_en};
				else group_en = d[1:0];
			end else if (off[11:2] == WOFF_TYPE) begin
				if (f == FUNC_READ) r.rdata = (BIT_WORDS - 1) & 32'h1F;
			end else if (page == PAGE_GROUP) begin
				if (m != '0) begin
					// reads fold the word index with the word-count mask
					if (f == FUNC_READ) r.rdata = group_word[w & 5'(BIT_WORDS - 1)] & m;
					else group_word[w] = d & m;
				end
			end else if (page == PAGE_SETEN) begin
				if (m != '0) begin
					if (f == FUNC_READ) r.rdata = enable_word[w] & m;
					else enable_word[w] = enable_word[w] | (d & m);
				end
			end else if (page == PAGE_CLREN) begin
				if (m != '0) begin
					if (f == FUNC_READ) r.rdata = enable_word[w] & m;
					else enable_word[w] = enable_word[w] & ~(d & m);
				end
			end else if (page == PAGE_CLRPND) begin
				// clear-pending: taken, no state behind it
			end else begin
				r.err = 1'b1;
			end
			if (f != FUNC_READ) r.rdata = '0;
			return r;
		endfunction

		function void note_access(logic [1:0] f, logic [11:0] off, logic [31:0] d);
			due_replies.push_back(predict_access(f, off, d));
		endfunction

		task check_reply(logic [31:0] rd, logic err);
			reply_t exp_r;
			if (due_replies.size() == 0) begin
				report($sformatf("reply with nothing outstanding (rdata %08h)", rd));
			end else begin
				exp_r = due_replies.pop_front();
				if (rd !== exp_r.rdata)
					report($sformatf("rdata %08h, want %08h", rd, exp_r.rdata));
				if (err !== exp_r.err)
					report($sformatf("access_error %b, want %b", err, exp_r.err));
			end
		endtask

		function int outstanding();
			return due_replies.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  func = FUNC_READ;
	logic [11:0] offset = '0;
	logic [31:0] wdata = '0;
	logic        busy;
	logic        done;
	logic [31:0] rdata;
	logic        access_error;

	regbank_model #(LINES) regbank;
	int beat_no = 0;

	interrupt_distributor_regs_top #(
		.NUM_LINES(LINES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.offset(offset),
		.wdata(wdata),
		.done(done),
		.rdata(rdata),
		.access_error(access_error)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watch both sides on the edge itself: values read here are the ones the
	// DUT sampled, so a beat is taken exactly when start is high and busy low.
	// A new beat is noted before the reply check; the queue keeps them ordered.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) regbank.note_access(func, offset, wdata);
			if (done) regbank.check_reply(rdata, access_error);
		end
	end

	// Optional idle gap, then present one beat and hold it until taken. Called
	// on a clock edge; returns on the edge that took the beat.
	// Beats 500 to 799 run back to back so the DUT sees full pressure.
	task automatic run_beat(input logic [1:0] f, input logic [11:0] off,
			input logic [31:0] d);
		int gap;
		gap = 0;
		if ((beat_no < 500 || beat_no >= 800) && $urandom_range(0, 99) < 33)
			gap = $urandom_range(1, 4);
		if (gap != 0) begin
			// idle beat content is junk the DUT must ignore
			start <= 1'b0;
			func <= 2'($urandom_range(0, 3));
			offset <= 12'($urandom_range(0, 4095));
			wdata <= $urandom;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		offset <= off;
		wdata <= d;
		do @(posedge clk); while (busy);
		beat_no++;
	endtask

	// Random access, steered at the implemented lines so that writes are
	// mostly read back, with a share of wholly random offsets and functions.
	task automatic random_beat();
		int sel;
		int fsel;
		logic [1:0]  f;
		logic [11:0] off;
		logic [31:0] d;
		sel = $urandom_range(0, 99);
		fsel = $urandom_range(0, 99);
		if (sel < 8)
			off = 12'($urandom_range(0, 7));                 // control, type
		else if (sel < 20)
			off = 12'(12'h080 + ($urandom_range(0, 3) == 0 ?
				$urandom_range(0, 127) : $urandom_range(0, 31)));
		else if (sel < 40)
			off = 12'(12'h100 + ($urandom_range(0, 3) == 0 ?
				$urandom_range(0, 255) : $urandom_range(0, 31) +
				($urandom_range(0, 1) ? 12'h080 : 12'h000)));
		else if (sel < 58)
			off = 12'(12'h400 + ($urandom_range(0, 3) == 0 ?
				$urandom_range(0, 1023) : $urandom_range(0, 255)));
		else if (sel < 76)
			off = 12'(12'h800 + ($urandom_range(0, 3) == 0 ?
				$urandom_range(0, 1023) : $urandom_range(0, 255)));
		else if (sel < 81)
			off = 12'(12'h280 + $urandom_range(0, 127));
		else
			off = 12'($urandom_range(0, 4095));
		if (fsel < 40) f = FUNC_READ;
		else if (fsel < 72) f = FUNC_WRITE;
		else if (fsel < 97) f = FUNC_BYTE;
		else f = FUNC_RSVD;
		case ($urandom_range(0, 9))
			0: d = '0;
			1: d = '1;
			default: d = $urandom;
		endcase
		run_beat(f, off, d);
	endtask

	initial begin
		int waited;
		regbank = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every window, the last implemented group and target words, the
		// first group word past the line count, lane bits, bad byte writes, bad func
		run_beat(FUNC_READ,  12'h004, '0);           // type register
		run_beat(FUNC_WRITE, 12'h004, '1);           // type is read-only
		run_beat(FUNC_WRITE, 12'h000, '1);
		run_beat(FUNC_READ,  12'h003, '0);           // lane bits ignored
		run_beat(FUNC_WRITE, 12'h080, '1);
		run_beat(FUNC_WRITE, 12'h09C, 32'hA5A5_5A5A); // last group word
		run_beat(FUNC_WRITE, 12'h0A0, '1);           // beyond line count
		run_beat(FUNC_READ,  12'h0A0, '0);
		run_beat(FUNC_WRITE, 12'h100, '1);
		run_beat(FUNC_WRITE, 12'h180, 32'h0000_FFFF);
		run_beat(FUNC_READ,  12'h100, '0);
		run_beat(FUNC_READ,  12'h180, '0);
		run_beat(FUNC_WRITE, 12'h400, '1);
		run_beat(FUNC_BYTE,  12'h401, 32'hFFFF_FF00); // byte uses bits 7..0
		run_beat(FUNC_READ,  12'h400, '0);
		run_beat(FUNC_BYTE,  12'h7FF, '1);           // line 1023, ignored
		run_beat(FUNC_WRITE, 12'h8FC, 32'h0102_0408);
		run_beat(FUNC_BYTE,  12'h8FF, 32'h0000_0080);
		run_beat(FUNC_READ,  12'h8FC, '0);
		run_beat(FUNC_BYTE,  12'h100, '1);           // byte write, bit window
		run_beat(FUNC_WRITE, 12'h2FC, '1);           // clear-pending
		run_beat(FUNC_READ,  12'h280, '0);
		run_beat(FUNC_READ,  12'hC00, '0);           // unmapped
		run_beat(FUNC_WRITE, 12'hFFF, '1);
		run_beat(FUNC_RSVD,  12'h000, '1);           // reserved function

		repeat (RND_BEATS) random_beat();
		start <= 1'b0;

		// drain, bounded; the watchdog below is the outer limit
		waited = 0;
		while (regbank.outstanding() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (regbank.outstanding() != 0)
			regbank.report($sformatf("%0d replies never came", regbank.outstanding()));

		if (regbank.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// watchdog: the slowest correct run is well under 100 us
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
